@@ sv/eib_pkg.sv @@
// shared types, constants and the radius-to-weight lookup for the exponential blur
// no dependencies
`default_nettype none
package eib_pkg;
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int POS_W       = ADDR_W + 1;
	localparam int DIM_W       = 9;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_AONLY  = 2'd3;

	localparam logic [1:0] PASS_DOWN  = 2'd0;
	localparam logic [1:0] PASS_RIGHT = 2'd1;
	localparam logic [1:0] PASS_UP    = 2'd2;
	localparam logic [1:0] PASS_LEFT  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_BL_RD,
		ST_BL_WR
	} state_t;

	function automatic logic [4:0] radius_weight(input logic [7:0] radius);
		logic [4:0] w;
		case (radius)
			8'd0:                      w = 5'd16;
			8'd1:                      w = 5'd14;
			8'd2:                      w = 5'd10;
			8'd3:                      w = 5'd8;
			8'd4:                      w = 5'd6;
			8'd5, 8'd6:                w = 5'd5;
			8'd7:                      w = 5'd4;
			8'd8, 8'd9, 8'd10, 8'd11:  w = 5'd3;
			8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17: w = 5'd2;
			default:                   w = 5'd1;
		endcase
		return w;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
		input logic [DIM_W-1:0] dmax);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) r = DIM_W'(1);
		else if (d > dmax) r = dmax;
		return r;
	endfunction
endpackage
`default_nettype wire

@@ sv/exponential_image_blur.sv @@
// exponential image blur: frame store, four-pass iir sweep and read-out
// depends on eib_pkg
`default_nettype none
// Load a frame pixel by pixel (action 0), one item a cycle while the output
// register is free. The item that completes the frame starts the blur, which
// sweeps the frame store four times (down, right, up, left); each pixel costs
// one memory read state and one update/write-back state. During the blur no
// item is accepted. Read items (action 1) then pass through the memory read
// and the output register, a new read being taken only once the last one has
// reached the output register, and return the pixels in raster order,
// last_pixel flagging the final one. A read before the blur has finished
// returns nothing.
module exponential_image_blur (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [31:0] pixel_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      pixel_out,
	output logic             last_pixel,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);
	localparam int AW = eib_pkg::ADDR_W;
	localparam int PW = eib_pkg::POS_W;
	localparam int DW = eib_pkg::DIM_W;

	logic [DW-1:0] width_q, height_q;
	logic [7:0]    radius_q;
	logic          aonly_q;

	logic [31:0] mem [eib_pkg::STORE_DEPTH];
	logic [31:0] rd_data_q;
	logic        mem_re, mem_we;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0] wr_data;

	eib_pkg::state_t state_q, state_d;
	logic [PW-1:0] load_pos_q, read_pos_q;
	logic          done_q;
	logic          last_q;
	logic [1:0]    pass_q;
	logic [DW-1:0] outer_q, step_q;
	logic [11:0]   acc_q [4];
	logic [11:0]   acc_d [4];
	logic [31:0]   upd_px;

	logic [DW-1:0] eff_w, eff_h, line_len, line_cnt, row, col;
	logic [2*DW-1:0] total, blur_prod;
	logic [4:0]    weight;
	logic          in_acc, out_acc;
	logic [PW:0]   load_next, read_next;

	assign eff_w   = eib_pkg::clamp_dim(width_q, DW'(eib_pkg::MAX_WIDTH));
	assign eff_h   = eib_pkg::clamp_dim(height_q, DW'(eib_pkg::MAX_HEIGHT));
	assign total   = eff_w * eff_h;
	assign weight  = eib_pkg::radius_weight(radius_q);
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	// the output register frees up in the same cycle its item leaves
	assign in_ready = (state_q == eib_pkg::ST_IDLE) && (!out_valid || out_ready);
	assign load_next = {1'b0, (done_q ? PW'(0) : load_pos_q)} + (PW+1)'(1);
	assign read_next = {1'b0, read_pos_q} + (PW+1)'(1);

	// sweep geometry: even passes walk columns, odd passes walk rows
	always_comb begin
		line_len = pass_q[0] ? eff_w : eff_h;
		line_cnt = pass_q[0] ? eff_h : eff_w;
		row = '0;
		col = '0;
		case (pass_q)
			eib_pkg::PASS_DOWN:  begin row = step_q; col = outer_q; end
			eib_pkg::PASS_RIGHT: begin row = outer_q; col = step_q; end
			eib_pkg::PASS_UP:    begin row = eff_h - DW'(1) - step_q; col = outer_q; end
			default:             begin row = outer_q; col = eff_w - DW'(1) - step_q; end
		endcase
		blur_prod = row * eff_w + (2*DW)'(col);
	end

	// per-channel iir update, division by 16 truncating toward zero
	always_comb begin
		logic signed [12:0] diff;
		logic signed [18:0] prod;
		logic signed [18:0] q;
		upd_px = rd_data_q;
		for (int c = 0; c < 4; c++) begin
			diff = $signed({1'b0, rd_data_q[8*c +: 8], 4'b0}) - $signed({1'b0, acc_q[c]});
			prod = 19'(diff) * $signed({14'b0, weight});
			q = (prod + (prod[18] ? 19'sd15 : 19'sd0)) >>> 4;
			acc_d[c] = acc_q[c] + q[11:0];
			if (c == 3 || !aonly_q) upd_px[8*c +: 8] = acc_d[c][11:4];
		end
	end

	always_comb begin
		mem_re  = 1'b0;
		mem_we  = 1'b0;
		rd_addr = read_pos_q[AW-1:0];
		wr_addr = load_pos_q[AW-1:0];
		wr_data = pixel_in;
		state_d = state_q;
		unique case (state_q)
			eib_pkg::ST_IDLE: begin
				if (in_acc && !action) begin
					mem_we  = 1'b1;
					wr_addr = done_q ? AW'(0) : load_pos_q[AW-1:0];
					if (load_next >= (PW+1)'(total)) state_d = eib_pkg::ST_BL_RD;
				end else if (in_acc && done_q) begin
					mem_re  = 1'b1;
					state_d = eib_pkg::ST_RD_WAIT;
				end
			end
			eib_pkg::ST_RD_WAIT: state_d = eib_pkg::ST_IDLE;
			eib_pkg::ST_BL_RD: begin
				mem_re  = 1'b1;
				rd_addr = blur_prod[AW-1:0];
				state_d = eib_pkg::ST_BL_WR;
			end
			eib_pkg::ST_BL_WR: begin
				wr_addr = blur_prod[AW-1:0];
				wr_data = upd_px;
				mem_we  = (step_q != '0);
				state_d = eib_pkg::ST_BL_RD;
				if (step_q == line_len - DW'(1) && outer_q == line_cnt - DW'(1) &&
					pass_q == eib_pkg::PASS_LEFT)
					state_d = eib_pkg::ST_IDLE;
			end
			default: state_d = eib_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		if (mem_re) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= eib_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DW'(256);
			height_q <= DW'(256);
			radius_q <= '0;
			aonly_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				eib_pkg::REG_WIDTH:  width_q  <= cfg_data;
				eib_pkg::REG_HEIGHT: height_q <= cfg_data;
				eib_pkg::REG_RADIUS: radius_q <= cfg_data[7:0];
				default:             aonly_q  <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			read_pos_q <= '0;
			done_q     <= 1'b0;
			last_q     <= 1'b0;
			pass_q     <= '0;
			outer_q    <= '0;
			step_q     <= '0;
			out_valid  <= 1'b0;
			pixel_out  <= '0;
			last_pixel <= 1'b0;
			for (int c = 0; c < 4; c++) acc_q[c] <= '0;
		end else begin
			if (out_acc) out_valid <= 1'b0;
			case (state_q)
				eib_pkg::ST_IDLE: begin
					if (in_acc && !action) begin
						done_q     <= 1'b0;
						read_pos_q <= '0;
						if (load_next >= (PW+1)'(total)) begin
							load_pos_q <= '0;
							pass_q     <= eib_pkg::PASS_DOWN;
							outer_q    <= '0;
							step_q     <= '0;
						end else begin
							load_pos_q <= load_next[PW-1:0];
						end
					end else if (in_acc && done_q) begin
						if (read_next >= (PW+1)'(total)) begin
							last_q     <= 1'b1;
							read_pos_q <= '0;
							load_pos_q <= '0;
							done_q     <= 1'b0;
						end else begin
							last_q     <= 1'b0;
							read_pos_q <= read_next[PW-1:0];
						end
					end
				end
				eib_pkg::ST_RD_WAIT: begin
					out_valid  <= 1'b1;
					pixel_out  <= rd_data_q;
					last_pixel <= last_q;
				end
				eib_pkg::ST_BL_WR: begin
					for (int c = 0; c < 4; c++) begin
						if (c == 3 || !aonly_q)
							acc_q[c] <= (step_q == '0) ? {rd_data_q[8*c +: 8], 4'b0}
								: acc_d[c];
					end
					if (step_q == line_len - DW'(1)) begin
						step_q <= '0;
						if (outer_q == line_cnt - DW'(1)) begin
							outer_q <= '0;
							if (pass_q == eib_pkg::PASS_LEFT) done_q <= 1'b1;
							pass_q <= pass_q + 2'd1;
						end else begin
							outer_q <= outer_q + DW'(1);
						end
					end else begin
						step_q <= step_q + DW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == eib_pkg::ST_RD_WAIT)
		else $error("result without a frame read");
	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == eib_pkg::ST_RD_WAIT |=> out_valid)
		else $error("frame read did not fill the output register");
	a_blur_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == eib_pkg::ST_BL_WR && state_d == eib_pkg::ST_IDLE) |=> done_q)
		else $error("blur finished without marking the frame done");
endmodule
`default_nettype wire
